@@ design/assert_macros.svh @@
// Assertion macros for the design files; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PRR_ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define PRR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define PRR_ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg)
`define PRR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

@@ design/prr_pkg.sv @@
// Types, constants and helpers for the raw raster decoder.
package prr_pkg;

  localparam int DIM_W       = 13;
  localparam int COL_W       = 12;
  localparam int SAMPLE_W    = 16;
  localparam int HOLD_W      = 40;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIM_W-1:0] MAX_WIDTH  = 13'd4096;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;

  localparam logic [1:0] KIND_BITMAP = 2'd0;
  localparam logic [1:0] KIND_GRAY   = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_KIND   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MAX   = 4'd3;

  typedef struct packed {
    logic [1:0]          pixel_kind;
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic [SAMPLE_W-1:0] sample_max;
  } cfg_t;

  typedef struct packed {
    logic                is_bitmap;
    logic [2:0]          last_idx;
    logic                row_end;
    logic                image_end;
    logic [SAMPLE_W-1:0] chan_first;
    logic [SAMPLE_W-1:0] chan_second;
    logic [SAMPLE_W-1:0] chan_third;
  } entry_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] chan_first;
    logic [SAMPLE_W-1:0] chan_second;
    logic [SAMPLE_W-1:0] chan_third;
    logic                row_end;
    logic                image_end;
    logic                run_last;
  } pixel_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] top);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > top) begin
      r = top;
    end
    return r;
  endfunction

endpackage

@@ design/prr_intf.sv @@
// Handshake channel interfaces: raster bytes in, pixels out, register writes.
interface prr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface prr_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] chan_first;
  logic [15:0] chan_second;
  logic [15:0] chan_third;
  logic        row_end;
  logic        image_end;
  logic        run_last;
  modport source (output valid, output chan_first, output chan_second, output chan_third,
                  output row_end, output image_end, output run_last, input ready);
  modport sink (input valid, input chan_first, input chan_second, input chan_third,
                input row_end, input image_end, input run_last, output ready);
endinterface

interface prr_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/pnm_raw_raster_decoder.sv @@
// Top level of the raw netpbm raster decoder.
//
// Unpacks a raw PBM/PGM/PPM raster, one byte per transfer, into pixels in raster order.
// Gray and RGB bytes are taken one per cycle while the work queue is not full; the pixel
// that a byte completes passes through the work queue and the output register. A bitmap
// byte yields min(8, pixels left in the row) pixels, and the back end sends them one per
// cycle while the output is ready; the two-entry work queue holds the byte being expanded
// and one more before the input stalls. Bytes after the last pixel of the image are taken
// and dropped. Any write to one of the four defined registers restarts the image.
`include "assert_macros.svh"

module pnm_raw_raster_decoder
  import prr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  prr_byte_if.sink  byte_i,
  prr_pix_if.source pix_o,
  prr_cfg_if.sink   cfg_i
);

  cfg_t   cfg_q, cfg_d;
  logic   cfg_hit;
  logic   q_full, push, pop, head_valid;
  entry_t push_entry, head;
  pixel_t out_pix;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d   = cfg_q;
    cfg_hit = 1'b0;
    if (cfg_i.valid) begin
      cfg_hit = 1'b1;
      case (cfg_i.index)
        REG_PIXEL_KIND:   cfg_d.pixel_kind   = cfg_i.data[1:0];
        REG_IMAGE_WIDTH:  cfg_d.image_width  = cfg_i.data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_d.image_height = cfg_i.data[DIM_W-1:0];
        REG_SAMPLE_MAX:   cfg_d.sample_max   = cfg_i.data;
        default:          cfg_hit            = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_kind   <= KIND_GRAY;
      cfg_q.image_width  <= DIM_W'(1);
      cfg_q.image_height <= DIM_W'(1);
      cfg_q.sample_max   <= 16'd255;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  prr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (cfg_hit),
    .cfg_i        (cfg_q),
    .in_valid_i   (byte_i.valid),
    .in_byte_i    (byte_i.data_byte),
    .in_ready_o   (byte_i.ready),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  prr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  prr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (pix_o.valid),
    .out_ready_i  (pix_o.ready),
    .out_pix_o    (out_pix)
  );

  assign pix_o.chan_first  = out_pix.chan_first;
  assign pix_o.chan_second = out_pix.chan_second;
  assign pix_o.chan_third  = out_pix.chan_third;
  assign pix_o.row_end     = out_pix.row_end;
  assign pix_o.image_end   = out_pix.image_end;
  assign pix_o.run_last    = out_pix.run_last;

  `PRR_ASSERT_IMPLIES(a_image_end_closes_row, clk_i, rst_ni,
    pix_o.valid && pix_o.image_end, pix_o.row_end && pix_o.run_last,
    "image end without row end and run end")
  `PRR_ASSERT_IMPLIES(a_mono_upper_zero, clk_i, rst_ni,
    pix_o.valid && (cfg_q.pixel_kind == KIND_BITMAP || cfg_q.pixel_kind == KIND_GRAY),
    pix_o.chan_second == 16'd0 && pix_o.chan_third == 16'd0,
    "green or blue set outside rgb mode")
  `PRR_ASSERT_IMPLIES(a_bitmap_one_bit, clk_i, rst_ni,
    pix_o.valid && cfg_q.pixel_kind == KIND_BITMAP, pix_o.chan_first[15:1] == 15'd0,
    "bitmap pixel wider than one bit")
  `PRR_ASSERT_NEXT(a_full_blocks_push, clk_i, rst_ni,
    q_full && !pop, !push || pop,
    "push into a full queue")

endmodule

@@ design/prr_front.sv @@
// Front end: accepts raster bytes, assembles samples, tracks position, queues work.
module prr_front
  import prr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clear_i,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       push_o,
  output entry_t     push_entry_o
);

  logic [HOLD_W-1:0] hold_q, hold_d;
  logic [2:0]        phase_q, phase_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [COL_W-1:0]  row_q, row_d;
  logic              done_q, done_d;

  logic [DIM_W-1:0]  w, h, left, row_next;
  logic [3:0]        bit_cnt, pix_cnt, need;
  logic              is_bitmap, wide, complete, row_last, img_last, take;
  logic [47:0]       v;

  always_comb begin
    w         = clamp_dim(cfg_i.image_width, MAX_WIDTH);
    h         = clamp_dim(cfg_i.image_height, MAX_HEIGHT);
    left      = w - DIM_W'(col_q);
    bit_cnt   = (left < DIM_W'(8)) ? left[3:0] : 4'd8;
    is_bitmap = (cfg_i.pixel_kind == KIND_BITMAP);
    wide      = (cfg_i.sample_max > 16'hFF);
    if (cfg_i.pixel_kind == KIND_GRAY) begin
      need = wide ? 4'd2 : 4'd1;
    end else begin
      need = wide ? 4'd6 : 4'd3;
    end
    v        = {hold_q, in_byte_i};
    complete = ({1'b0, phase_q} + 4'd1) >= need;
    pix_cnt  = is_bitmap ? bit_cnt : 4'd1;
    row_last = left <= DIM_W'(pix_cnt);
    row_next = DIM_W'(row_q) + DIM_W'(1);
    img_last = row_last && (row_next >= h);
  end

  assign in_ready_o = done_q || !q_full_i;
  assign take       = in_valid_i && in_ready_o && !done_q;
  assign push_o     = take && (is_bitmap || complete);

  always_comb begin
    push_entry_o.is_bitmap = is_bitmap;
    push_entry_o.last_idx  = is_bitmap ? 3'(bit_cnt - 4'd1) : 3'd0;
    push_entry_o.row_end   = row_last;
    push_entry_o.image_end = img_last;
    push_entry_o.chan_second = '0;
    push_entry_o.chan_third  = '0;
    if (is_bitmap) begin
      push_entry_o.chan_first = {8'h00, in_byte_i};
    end else if (cfg_i.pixel_kind == KIND_GRAY) begin
      push_entry_o.chan_first = wide ? v[15:0] : {8'h00, v[7:0]};
    end else if (wide) begin
      push_entry_o.chan_first  = v[47:32];
      push_entry_o.chan_second = v[31:16];
      push_entry_o.chan_third  = v[15:0];
    end else begin
      push_entry_o.chan_first  = {8'h00, v[23:16]};
      push_entry_o.chan_second = {8'h00, v[15:8]};
      push_entry_o.chan_third  = {8'h00, v[7:0]};
    end
  end

  always_comb begin
    hold_d  = hold_q;
    phase_d = phase_q;
    col_d   = col_q;
    row_d   = row_q;
    done_d  = done_q;
    if (clear_i) begin
      hold_d  = '0;
      phase_d = '0;
      col_d   = '0;
      row_d   = '0;
      done_d  = 1'b0;
    end else if (take) begin
      if (!is_bitmap) begin
        if (complete) begin
          hold_d  = '0;
          phase_d = '0;
        end else begin
          hold_d  = v[HOLD_W-1:0];
          phase_d = phase_q + 3'd1;
        end
      end
      if (push_o) begin
        if (row_last) begin
          col_d = '0;
          if (img_last) begin
            done_d = 1'b1;
            row_d  = '0;
          end else begin
            row_d = row_q + COL_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(pix_cnt);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= '0;
      phase_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      hold_q  <= hold_d;
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      done_q  <= done_d;
    end
  end

endmodule

@@ design/prr_queue.sv @@
// Short work queue between the front end and the pixel sequencer.
module prr_queue
  import prr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   head_valid_o,
  output entry_t head_o
);

  entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

@@ design/prr_back.sv @@
// Back end: expands queued work into pixels, one per cycle while the output is ready, into the output register.
module prr_back
  import prr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   head_valid_i,
  input  entry_t head_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output pixel_t out_pix_o
);

  logic [2:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  pixel_t     pix_q, pix_d;
  logic       load, last;

  assign load  = head_valid_i && (!valid_q || out_ready_i);
  assign last  = (idx_q == head_i.last_idx);
  assign pop_o = load && last;

  always_comb begin
    pix_d.chan_first  = head_i.chan_first;
    pix_d.chan_second = head_i.chan_second;
    pix_d.chan_third  = head_i.chan_third;
    if (head_i.is_bitmap) begin
      pix_d.chan_first = {15'd0, head_i.chan_first[3'd7 - idx_q]};
    end
    pix_d.row_end   = last && head_i.row_end;
    pix_d.image_end = last && head_i.image_end;
    pix_d.run_last  = last;
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = last ? 3'd0 : idx_q + 3'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q <= pix_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_pix_o   = pix_q;

endmodule

@@ test/tb.sv @@
// Testbench for the raw raster decoder: drives raster bytes and register writes, checks pixels.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prr_pkg::*;

  localparam logic [1:0] KIND_RGB = 2'd2;
  localparam logic [1:0] KIND_ODD = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 4'd4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 160;
  localparam int RANDOM_ITEMS = 110;

  class pixel_board;
    logic [1:0]          kind;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [SAMPLE_W-1:0] smax;
    logic [HOLD_W-1:0]   holding;
    int unsigned         phase;
    int unsigned         col;
    int unsigned         row;
    bit                  done;
    pixel_t              pixels_due[$];
    int unsigned         mismatches;

    function new();
      kind = KIND_GRAY;
      width = 1;
      height = 1;
      smax = 255;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      holding = '0;
      phase = 0;
      col = 0;
      row = 0;
      done = 1'b0;
    endfunction

    function int unsigned dim_of(input logic [DIM_W-1:0] v, input logic [DIM_W-1:0] top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function void note_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
      case (idx)
        REG_PIXEL_KIND: kind = d[1:0];
        REG_IMAGE_WIDTH: width = d[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height = d[DIM_W-1:0];
        REG_SAMPLE_MAX: smax = d;
        default: return;
      endcase
      restart();
    endfunction

    function pixel_t place_pixel(input logic [15:0] c1, c2, c3);
      pixel_t px;
      px.chan_first = c1;
      px.chan_second = c2;
      px.chan_third = c3;
      px.row_end = 1'b0;
      px.image_end = 1'b0;
      px.run_last = 1'b0;
      if (col + 1 >= dim_of(width, MAX_WIDTH)) begin
        px.row_end = 1'b1;
        col = 0;
        if (row + 1 >= dim_of(height, MAX_HEIGHT)) begin
          px.image_end = 1'b1;
          done = 1'b1;
          row = 0;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
      return px;
    endfunction

    function void note_byte(input logic [7:0] b);
      pixel_t      last;
      int unsigned w;
      int unsigned left;
      int unsigned cnt;
      int unsigned need;
      int unsigned n;
      bit          wide;
      logic [47:0] v;
      if (done) return;
      n = 0;
      if (kind == KIND_BITMAP) begin
        w = dim_of(width, MAX_WIDTH);
        left = (col < w) ? w - col : 1;
        cnt = (left < 8) ? left : 8;
        for (int i = 0; i < cnt && !done; i++) begin
          if (n > 0) pixels_due.push_back(last);
          last = place_pixel({15'd0, b[7-i]}, 16'd0, 16'd0);
          n++;
        end
      end else begin
        wide = smax > 16'd255;
        need = (kind == KIND_GRAY) ? (wide ? 2 : 1) : (wide ? 6 : 3);
        v = {holding, b};
        if (phase + 1 >= need) begin
          holding = '0;
          phase = 0;
          if (kind == KIND_GRAY) begin
            last = place_pixel(wide ? v[15:0] : {8'd0, v[7:0]}, 16'd0, 16'd0);
          end else if (wide) begin
            last = place_pixel(v[47:32], v[31:16], v[15:0]);
          end else begin
            last = place_pixel({8'd0, v[23:16]}, {8'd0, v[15:8]}, {8'd0, v[7:0]});
          end
          n = 1;
        end else begin
          holding = v[HOLD_W-1:0];
          phase++;
        end
      end
      if (n > 0) begin
        last.run_last = 1'b1;
        pixels_due.push_back(last);
      end
    endfunction

    function void check_pixel(input pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected pixel %h %h %h re=%b ie=%b last=%b", got.chan_first,
                   got.chan_second, got.chan_third, got.row_end, got.image_end, got.run_last);
        return;
      end
      want = pixels_due.pop_front();
      if (got.chan_first !== want.chan_first || got.chan_second !== want.chan_second ||
          got.chan_third !== want.chan_third || got.row_end !== want.row_end ||
          got.image_end !== want.image_end || got.run_last !== want.run_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: mismatch: exp %h %h %h re=%b ie=%b last=%b, got %h %h %h %b %b %b",
                   want.chan_first, want.chan_second, want.chan_third, want.row_end,
                   want.image_end, want.run_last, got.chan_first, got.chan_second,
                   got.chan_third, got.row_end, got.image_end, got.run_last);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  prr_byte_if byte_if();
  prr_pix_if  pix_if();
  prr_cfg_if  cfg_if();

  pnm_raw_raster_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .pix_o  (pix_if),
    .cfg_i  (cfg_if)
  );

  pixel_board  sb;
  pixel_t      seen;
  bit          calm_in;
  bit          calm_out;
  bit          hold_ask;
  int unsigned cycles;

  assign seen = {pix_if.chan_first, pix_if.chan_second, pix_if.chan_third,
                 pix_if.row_end, pix_if.image_end, pix_if.run_last};

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pix_if.valid === 1'b1 && pix_if.ready) sb.check_pixel(seen);
  end

  initial begin
    pix_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_ask) begin
        hold_ask = 1'b0;
        pix_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      pix_if.ready = calm_out || ($urandom_range(0, 99) >= 26);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm_in && $urandom_range(0, 99) < 26) begin
      byte_if.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    byte_if.valid = 1'b1;
    byte_if.data_byte = b;
    do @(posedge clk_i); while (byte_if.ready !== 1'b1);
    sb.note_byte(b);
    @(negedge clk_i);
  endtask

  task automatic drain();
    byte_if.valid = 1'b0;
    while (sb.pixels_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = d;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.note_reg(idx, d);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic setup(input logic [15:0] kind_d, w_d, h_d, s_d);
    drain();
    write_reg(REG_PIXEL_KIND, kind_d);
    write_reg(REG_IMAGE_WIDTH, w_d);
    write_reg(REG_IMAGE_HEIGHT, h_d);
    write_reg(REG_SAMPLE_MAX, s_d);
  endtask

  initial begin
    logic [15:0] kind_d;
    logic [15:0] w_d;
    logic [15:0] h_d;
    logic [15:0] s_d;
    int unsigned per_px;
    int unsigned row_bytes;
    int unsigned total;
    int unsigned count;
    int unsigned sent;

    sb = new();
    rst_ni = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.data_byte = 8'd0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    calm_in = 1'b0;
    calm_out = 1'b0;
    hold_ask = 1'b0;
    cycles = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_byte(8'h00);
    send_byte(8'hFF);
    setup(16'(KIND_BITMAP), 16'd10, 16'd2, 16'd255);
    send_byte(8'hA5);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hC0);
    send_byte(8'h55);
    setup(16'(KIND_GRAY), 16'd2, 16'd1, 16'hFFFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h01);
    setup(16'(KIND_ODD), 16'd1, 16'd1, 16'd0);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    setup(16'(KIND_RGB), 16'd1, 16'd1, 16'd256);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(8'hFE);
    setup(16'(KIND_GRAY), 16'd1, 16'd2, 16'd300);
    send_byte(8'hAB);
    drain();
    write_reg(REG_COUNT, 16'hFFFF);
    send_byte(8'hCD);
    send_byte(8'h11);
    drain();
    write_reg(REG_SAMPLE_MAX, 16'd300);
    send_byte(8'h22);
    send_byte(8'h33);

    // fill the block while the pixel side holds off
    setup(16'(KIND_BITMAP), 16'hFFFF, 16'd1, 16'd255);
    calm_in = 1'b1;
    hold_ask = 1'b1;
    repeat (24) send_byte(8'($urandom_range(0, 255)));
    calm_in = 1'b0;
    drain();
    repeat (6) send_byte(8'($urandom_range(0, 255)));

    calm_in = 1'b1;
    calm_out = 1'b1;
    setup(16'(KIND_GRAY), 16'd40, 16'd0, 16'd255);
    repeat (41) send_byte(8'($urandom_range(0, 255)));
    drain();
    calm_in = 1'b0;
    calm_out = 1'b0;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind_d = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) kind_d = kind_d | 16'hFFFC;
      if ($urandom_range(0, 9) < 8) begin
        w_d = 16'($urandom_range(1, 12));
      end else begin
        case ($urandom_range(0, 3))
          0: w_d = 16'd0;
          1: w_d = 16'd4095;
          2: w_d = 16'd4096;
          default: w_d = 16'hFFFF;
        endcase
      end
      if ($urandom_range(0, 9) < 8) begin
        h_d = 16'($urandom_range(1, 4));
      end else begin
        case ($urandom_range(0, 2))
          0: h_d = 16'd0;
          1: h_d = 16'd4096;
          default: h_d = 16'hFFFF;
        endcase
      end
      case ($urandom_range(0, 5))
        0: s_d = 16'd0;
        1: s_d = 16'd1;
        2: s_d = 16'd255;
        3: s_d = 16'd256;
        4: s_d = 16'hFFFF;
        default: s_d = 16'($urandom_range(0, 65535));
      endcase
      setup(kind_d, w_d, h_d, s_d);
      if ($urandom_range(0, 5) == 0)
        write_reg(REG_COUNT + 4'($urandom_range(0, 11)), 16'($urandom_range(0, 65535)));

      per_px = (s_d > 16'd255) ? 2 : 1;
      if (kind_d[1:0] != KIND_GRAY) per_px = per_px * 3;
      row_bytes = sb.dim_of(w_d[DIM_W-1:0], MAX_WIDTH);
      if (kind_d[1:0] == KIND_BITMAP) row_bytes = (row_bytes + 7) / 8;
      else row_bytes = row_bytes * per_px;
      total = row_bytes * sb.dim_of(h_d[DIM_W-1:0], MAX_HEIGHT);
      if (total > 60) count = $urandom_range(4, 24);
      else if ($urandom_range(0, 6) == 0) count = $urandom_range(1, total);
      else count = total + $urandom_range(0, 2);

      repeat (count) begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
